// ===== hdl/asp_pkg.sv =====
// ----------------------------------------------------------------------------
// asp_pkg: shared constants, types and helpers for the escape sequence parser
// Holds byte codes, command codes, configuration indexes, the palette and
// the control and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package asp_pkg;

	// Default number of CSI parameter slots.
	localparam int PARAM_SLOTS_DEF = 16;

	// Payload widths.
	localparam int BYTE_W   = 8;
	localparam int CMD_W    = 4;
	localparam int GLYPH_W  = 7;
	localparam int COLOUR_W = 32;
	localparam int ATTR_W   = 3;
	localparam int PARAM_W  = 16;
	localparam int CFG_IDX_W = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG = 4'd1;

	// Reset values of the default colour registers.
	localparam logic [COLOUR_W-1:0] DEFAULT_FG_RST = 32'hFFCC_CCCC;
	localparam logic [COLOUR_W-1:0] DEFAULT_BG_RST = 32'hFF00_0000;

	// Byte codes.
	localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
	localparam logic [BYTE_W-1:0] CH_LBR    = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
	localparam logic [BYTE_W-1:0] CH_PRT_LO = 8'h20;
	localparam logic [BYTE_W-1:0] CH_PRT_HI = 8'h7E;
	localparam logic [BYTE_W-1:0] CH_FIN_LO = 8'h40;
	localparam logic [BYTE_W-1:0] CH_FIN_HI = 8'h7E;
	localparam logic [BYTE_W-1:0] CH_CUP    = 8'h48; // H
	localparam logic [BYTE_W-1:0] CH_HVP    = 8'h66; // f
	localparam logic [BYTE_W-1:0] CH_CUU    = 8'h41; // A
	localparam logic [BYTE_W-1:0] CH_CUD    = 8'h42; // B
	localparam logic [BYTE_W-1:0] CH_CUF    = 8'h43; // C
	localparam logic [BYTE_W-1:0] CH_CUB    = 8'h44; // D
	localparam logic [BYTE_W-1:0] CH_ED     = 8'h4A; // J
	localparam logic [BYTE_W-1:0] CH_EL     = 8'h4B; // K
	localparam logic [BYTE_W-1:0] CH_SGR    = 8'h6D; // m

	// Display command codes.
	localparam logic [CMD_W-1:0] CMD_PUT_CHAR   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_CR         = 4'd1;
	localparam logic [CMD_W-1:0] CMD_NEW_LINE   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_BACKSPACE  = 4'd3;
	localparam logic [CMD_W-1:0] CMD_SET_CURSOR = 4'd4;
	localparam logic [CMD_W-1:0] CMD_UP         = 4'd5;
	localparam logic [CMD_W-1:0] CMD_DOWN       = 4'd6;
	localparam logic [CMD_W-1:0] CMD_FORWARD    = 4'd7;
	localparam logic [CMD_W-1:0] CMD_BACK       = 4'd8;
	localparam logic [CMD_W-1:0] CMD_CLR_SCREEN = 4'd9;
	localparam logic [CMD_W-1:0] CMD_CLR_EOL    = 4'd10;
	localparam logic [CMD_W-1:0] CMD_CLR_BOL    = 4'd11;
	localparam logic [CMD_W-1:0] CMD_CLR_LINE   = 4'd12;

	// SGR parameter values.
	localparam logic [PARAM_W-1:0] SGR_RESET     = 16'd0;
	localparam logic [PARAM_W-1:0] SGR_BOLD      = 16'd1;
	localparam logic [PARAM_W-1:0] SGR_UNDERLINE = 16'd4;
	localparam logic [PARAM_W-1:0] SGR_REVERSE   = 16'd7;
	localparam logic [PARAM_W-1:0] SGR_FG_LO     = 16'd30;
	localparam logic [PARAM_W-1:0] SGR_FG_HI     = 16'd37;
	localparam logic [PARAM_W-1:0] SGR_FG_DEF    = 16'd39;
	localparam logic [PARAM_W-1:0] SGR_BG_LO     = 16'd40;
	localparam logic [PARAM_W-1:0] SGR_BG_HI     = 16'd47;
	localparam logic [PARAM_W-1:0] SGR_BG_DEF    = 16'd49;

	// Erase modes.
	localparam logic [PARAM_W-1:0] ERASE_FROM = 16'd0;
	localparam logic [PARAM_W-1:0] ERASE_TO   = 16'd1;
	localparam logic [PARAM_W-1:0] ERASE_ALL  = 16'd2;

	// Attribute bits.
	localparam logic [ATTR_W-1:0] ATTR_BOLD      = 3'b001;
	localparam logic [ATTR_W-1:0] ATTR_UNDERLINE = 3'b010;
	localparam logic [ATTR_W-1:0] ATTR_REVERSE   = 3'b100;

	// Eight-colour palette.
	function automatic logic [COLOUR_W-1:0] palette(input logic [2:0] idx);
		logic [COLOUR_W-1:0] c;
		case (idx)
			3'd0: c = 32'hFF00_0000;
			3'd1: c = 32'hFFFF_5555;
			3'd2: c = 32'hFF55_FF55;
			3'd3: c = 32'hFFFF_FF55;
			3'd4: c = 32'hFF55_55FF;
			3'd5: c = 32'hFFFF_55FF;
			3'd6: c = 32'hFF55_FFFF;
			default: c = 32'hFFCC_CCCC;
		endcase
		return c;
	endfunction

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_esc;
		logic is_lbr;
		logic is_digit;
		logic is_semi;
		logic is_final;
		logic is_sgr;
		logic sgr_empty;
		logic walk_last;
		logic out_free;
	} asp_status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic put_normal;
		logic csi_start;
		logic digit;
		logic semi;
		logic final_commit;
		logic exec;
		logic sgr_read;
		logic sgr_apply;
	} asp_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/asp_ctrl.sv =====
// ----------------------------------------------------------------------------
// asp_ctrl: parser controller
// Tracks the parse mode, holds off input while a final byte is executed and
// sequences the walk over the stored SGR parameters.
// ----------------------------------------------------------------------------
`default_nettype none

module asp_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_stall,
	input  wire asp_pkg::asp_status_t status,
	output asp_pkg::asp_ctrl_t       ctrl
);

	localparam logic [2:0] ST_NORMAL = 3'd0;
	localparam logic [2:0] ST_ESCAPE = 3'd1;
	localparam logic [2:0] ST_CSI    = 3'd2;
	localparam logic [2:0] ST_EXEC   = 3'd3;
	localparam logic [2:0] ST_SGR_RD = 3'd4;
	localparam logic [2:0] ST_SGR_AP = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       parse_st;
	logic       accept;

	// Input is taken only in a parse mode and when the output slot can take a result.
	assign parse_st   = (state_q == ST_NORMAL) || (state_q == ST_ESCAPE) || (state_q == ST_CSI);
	assign byte_stall = !parse_st || !status.out_free;
	assign accept     = byte_valid && !byte_stall;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		unique case (state_q)
			ST_NORMAL: begin
				if (accept) begin
					ctrl.put_normal = 1'b1;
					if (status.is_esc) begin
						state_d = ST_ESCAPE;
					end
				end
			end
			ST_ESCAPE: begin
				if (accept) begin
					if (status.is_lbr) begin
						ctrl.csi_start = 1'b1;
						state_d        = ST_CSI;
					end else begin
						state_d = ST_NORMAL;
					end
				end
			end
			ST_CSI: begin
				if (accept) begin
					if (status.is_digit) begin
						ctrl.digit = 1'b1;
					end else if (status.is_semi) begin
						ctrl.semi = 1'b1;
					end else if (status.is_final) begin
						ctrl.final_commit = 1'b1;
						state_d           = ST_EXEC;
					end
				end
			end
			ST_EXEC: begin
				if (status.out_free) begin
					ctrl.exec = 1'b1;
					if (status.is_sgr && !status.sgr_empty) begin
						state_d = ST_SGR_RD;
					end else begin
						state_d = ST_NORMAL;
					end
				end
			end
			ST_SGR_RD: begin
				ctrl.sgr_read = 1'b1;
				state_d       = ST_SGR_AP;
			end
			ST_SGR_AP: begin
				ctrl.sgr_apply = 1'b1;
				if (status.walk_last) begin
					state_d = ST_NORMAL;
				end else begin
					state_d = ST_SGR_RD;
				end
			end
			default: begin
				state_d = ST_NORMAL;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_NORMAL;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/asp_datapath.sv =====
// ----------------------------------------------------------------------------
// asp_datapath: parser datapath
// Classifies bytes, accumulates decimal parameters into the parameter store,
// keeps the colour and attribute state and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module asp_datapath #(
	parameter int PARAM_SLOTS = asp_pkg::PARAM_SLOTS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire asp_pkg::asp_ctrl_t                ctrl,
	output asp_pkg::asp_status_t                   status,
	input  wire logic [asp_pkg::BYTE_W-1:0]        byte_in,
	input  wire logic                              cfg_we,
	input  wire logic [asp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [asp_pkg::COLOUR_W-1:0]      cfg_data,
	output logic                                   cmd_valid,
	input  wire logic                              cmd_stall,
	output logic [asp_pkg::CMD_W-1:0]              command,
	output logic [asp_pkg::GLYPH_W-1:0]            glyph,
	output logic [asp_pkg::COLOUR_W-1:0]           fore_colour,
	output logic [asp_pkg::COLOUR_W-1:0]           back_colour,
	output logic [asp_pkg::ATTR_W-1:0]             attributes,
	output logic [asp_pkg::PARAM_W-1:0]            target_row,
	output logic [asp_pkg::PARAM_W-1:0]            target_col,
	output logic [asp_pkg::PARAM_W-1:0]            move_count
);

	localparam int CW = $clog2(PARAM_SLOTS + 1);
	localparam int IW = $clog2(PARAM_SLOTS);
	localparam int PW = asp_pkg::PARAM_W;

	// Parameter store and its read register.
	logic [PW-1:0] store_mem [PARAM_SLOTS];
	logic [PW-1:0] rd_q;

	// Parser state.
	logic [CW-1:0] count_q;
	logic          digit_q;
	logic [IW-1:0] idx_q;
	logic [PW-1:0] acc_q;
	logic [PW-1:0] p0_q;
	logic [PW-1:0] p1_q;
	logic [asp_pkg::BYTE_W-1:0] fin_q;

	// Colour and attribute state.
	logic [asp_pkg::COLOUR_W-1:0] dflt_fg_q;
	logic [asp_pkg::COLOUR_W-1:0] dflt_bg_q;
	logic [asp_pkg::COLOUR_W-1:0] fore_q;
	logic [asp_pkg::COLOUR_W-1:0] back_q;
	logic [asp_pkg::ATTR_W-1:0]   attr_q;

	// Result register.
	logic                         out_valid_q;
	logic [asp_pkg::CMD_W-1:0]    out_cmd_q;
	logic [asp_pkg::GLYPH_W-1:0]  out_glyph_q;
	logic [asp_pkg::COLOUR_W-1:0] out_fore_q;
	logic [asp_pkg::COLOUR_W-1:0] out_back_q;
	logic [asp_pkg::ATTR_W-1:0]   out_attr_q;
	logic [PW-1:0]                out_row_q;
	logic [PW-1:0]                out_col_q;
	logic [PW-1:0]                out_cnt_q;

	logic          out_free;
	logic          semi_ok;
	logic          commit;
	logic [19:0]   acc_sum;
	logic [PW-1:0] acc_next;

	// Normal-mode result.
	logic                         nrm_valid;
	logic [asp_pkg::CMD_W-1:0]    nrm_cmd;
	logic [asp_pkg::GLYPH_W-1:0]  nrm_glyph;
	logic [asp_pkg::COLOUR_W-1:0] nrm_fore;
	logic [asp_pkg::COLOUR_W-1:0] nrm_back;
	logic [asp_pkg::ATTR_W-1:0]   nrm_attr;

	// Final-byte result.
	logic          has_p0;
	logic          has_p1;
	logic [PW-1:0] arg1;
	logic [PW-1:0] arg2;
	logic [PW-1:0] erase_mode;
	logic [PW-1:0] move_n;
	logic          dec_valid;
	logic [asp_pkg::CMD_W-1:0] dec_cmd;
	logic [PW-1:0] dec_row;
	logic [PW-1:0] dec_col;
	logic [PW-1:0] dec_cnt;
	logic [PW-1:0] fg_off;
	logic [PW-1:0] bg_off;

	// Byte classes and walk status for the controller.
	always_comb begin
		status           = '0;
		status.is_esc    = (byte_in == asp_pkg::CH_ESC);
		status.is_lbr    = (byte_in == asp_pkg::CH_LBR);
		status.is_digit  = (byte_in >= asp_pkg::CH_ZERO) && (byte_in <= asp_pkg::CH_NINE);
		status.is_semi   = (byte_in == asp_pkg::CH_SEMI);
		status.is_final  = (byte_in >= asp_pkg::CH_FIN_LO) && (byte_in <= asp_pkg::CH_FIN_HI);
		status.is_sgr    = (fin_q == asp_pkg::CH_SGR);
		status.sgr_empty = (count_q == '0);
		status.walk_last = ((CW'(idx_q) + CW'(1)) == count_q);
		status.out_free  = out_free;
	end

	assign out_free = !out_valid_q || !cmd_stall;

	// A separator advances only while a free slot is left.
	assign semi_ok = ctrl.semi && (count_q < CW'(PARAM_SLOTS - 1));
	assign commit  = semi_ok || ctrl.final_commit;

	// Decimal accumulate: acc * 10 + digit, saturating at the field maximum.
	assign acc_sum  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {16'd0, byte_in[3:0]};
	assign acc_next = (|acc_sum[19:16]) ? {PW{1'b1}} : acc_sum[PW-1:0];

	// Result for a byte in normal mode.
	always_comb begin
		nrm_valid = 1'b1;
		nrm_cmd   = asp_pkg::CMD_PUT_CHAR;
		nrm_glyph = '0;
		nrm_fore  = '0;
		nrm_back  = '0;
		nrm_attr  = '0;
		unique case (byte_in) inside
			asp_pkg::CH_CR: begin
				nrm_cmd = asp_pkg::CMD_CR;
			end
			asp_pkg::CH_LF: begin
				nrm_cmd  = asp_pkg::CMD_NEW_LINE;
				nrm_back = back_q;
			end
			asp_pkg::CH_BS: begin
				nrm_cmd = asp_pkg::CMD_BACKSPACE;
			end
			[asp_pkg::CH_PRT_LO:asp_pkg::CH_PRT_HI]: begin
				nrm_cmd   = asp_pkg::CMD_PUT_CHAR;
				nrm_glyph = byte_in[asp_pkg::GLYPH_W-1:0];
				nrm_fore  = fore_q;
				nrm_back  = back_q;
				nrm_attr  = attr_q;
			end
			default: begin
				nrm_valid = 1'b0;
			end
		endcase
	end

	// Parameter defaults for the final byte.
	assign has_p0     = (count_q != '0);
	assign has_p1     = (count_q >= CW'(2));
	assign arg1       = has_p0 ? p0_q : PW'(1);
	assign arg2       = has_p1 ? p1_q : PW'(1);
	assign erase_mode = has_p0 ? p0_q : '0;
	assign move_n     = (arg1 == '0) ? PW'(1) : arg1;

	// Command decode of the final byte.
	always_comb begin
		dec_valid = 1'b1;
		dec_cmd   = asp_pkg::CMD_SET_CURSOR;
		dec_row   = '0;
		dec_col   = '0;
		dec_cnt   = '0;
		unique case (fin_q) inside
			asp_pkg::CH_CUP, asp_pkg::CH_HVP: begin
				dec_cmd = asp_pkg::CMD_SET_CURSOR;
				dec_row = (arg1 != '0) ? arg1 - PW'(1) : '0;
				dec_col = (arg2 != '0) ? arg2 - PW'(1) : '0;
			end
			asp_pkg::CH_CUU: begin
				dec_cmd = asp_pkg::CMD_UP;
				dec_cnt = move_n;
			end
			asp_pkg::CH_CUD: begin
				dec_cmd = asp_pkg::CMD_DOWN;
				dec_cnt = move_n;
			end
			asp_pkg::CH_CUF: begin
				dec_cmd = asp_pkg::CMD_FORWARD;
				dec_cnt = move_n;
			end
			asp_pkg::CH_CUB: begin
				dec_cmd = asp_pkg::CMD_BACK;
				dec_cnt = move_n;
			end
			asp_pkg::CH_ED: begin
				dec_cmd   = asp_pkg::CMD_CLR_SCREEN;
				dec_valid = (erase_mode == asp_pkg::ERASE_ALL);
			end
			asp_pkg::CH_EL: begin
				case (erase_mode)
					asp_pkg::ERASE_FROM: dec_cmd = asp_pkg::CMD_CLR_EOL;
					asp_pkg::ERASE_TO:   dec_cmd = asp_pkg::CMD_CLR_BOL;
					asp_pkg::ERASE_ALL:  dec_cmd = asp_pkg::CMD_CLR_LINE;
					default:             dec_valid = 1'b0;
				endcase
			end
			default: begin
				dec_valid = 1'b0;
			end
		endcase
	end

	// Palette offsets for SGR colour codes.
	assign fg_off = rd_q - asp_pkg::SGR_FG_LO;
	assign bg_off = rd_q - asp_pkg::SGR_BG_LO;

	// Parameter store: one write port at the slot count, one registered read port.
	always_ff @(posedge clk) begin
		if (commit) begin
			store_mem[count_q[IW-1:0]] <= acc_q;
		end
		if (ctrl.sgr_read) begin
			rd_q <= store_mem[idx_q];
		end
	end

	// Parameter payload registers.
	always_ff @(posedge clk) begin
		if (ctrl.csi_start || semi_ok) begin
			acc_q <= '0;
		end else if (ctrl.digit) begin
			acc_q <= acc_next;
		end
		if (commit && (count_q == CW'(0))) begin
			p0_q <= acc_q;
		end
		if (commit && (count_q == CW'(1))) begin
			p1_q <= acc_q;
		end
		if (ctrl.final_commit) begin
			fin_q <= byte_in;
		end
	end

	// Parser control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			digit_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (ctrl.csi_start) begin
				count_q <= '0;
				digit_q <= 1'b0;
			end else if (ctrl.digit) begin
				digit_q <= 1'b1;
			end else if (semi_ok) begin
				count_q <= count_q + CW'(1);
				digit_q <= 1'b0;
			end else if (ctrl.final_commit) begin
				count_q <= count_q + CW'(digit_q);
			end
			if (ctrl.exec) begin
				idx_q <= '0;
			end else if (ctrl.sgr_apply) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// Default colour registers and current rendition.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_fg_q <= asp_pkg::DEFAULT_FG_RST;
			dflt_bg_q <= asp_pkg::DEFAULT_BG_RST;
			fore_q    <= asp_pkg::DEFAULT_FG_RST;
			back_q    <= asp_pkg::DEFAULT_BG_RST;
			attr_q    <= '0;
		end else begin
			if (cfg_we && (cfg_index == asp_pkg::CFG_DEFAULT_FG)) begin
				dflt_fg_q <= cfg_data;
			end
			if (cfg_we && (cfg_index == asp_pkg::CFG_DEFAULT_BG)) begin
				dflt_bg_q <= cfg_data;
			end
			if (ctrl.exec && status.is_sgr && status.sgr_empty) begin
				fore_q <= dflt_fg_q;
				back_q <= dflt_bg_q;
				attr_q <= '0;
			end else if (ctrl.sgr_apply) begin
				case (rd_q) inside
					asp_pkg::SGR_RESET: begin
						fore_q <= dflt_fg_q;
						back_q <= dflt_bg_q;
						attr_q <= '0;
					end
					asp_pkg::SGR_BOLD:      attr_q <= attr_q | asp_pkg::ATTR_BOLD;
					asp_pkg::SGR_UNDERLINE: attr_q <= attr_q | asp_pkg::ATTR_UNDERLINE;
					asp_pkg::SGR_REVERSE:   attr_q <= attr_q | asp_pkg::ATTR_REVERSE;
					[asp_pkg::SGR_FG_LO:asp_pkg::SGR_FG_HI]: fore_q <= asp_pkg::palette(fg_off[2:0]);
					asp_pkg::SGR_FG_DEF:    fore_q <= dflt_fg_q;
					[asp_pkg::SGR_BG_LO:asp_pkg::SGR_BG_HI]: back_q <= asp_pkg::palette(bg_off[2:0]);
					asp_pkg::SGR_BG_DEF:    back_q <= dflt_bg_q;
					default: begin
					end
				endcase
			end
		end
	end

	// Result valid flag: set on a load, cleared when the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctrl.put_normal && nrm_valid) || (ctrl.exec && dec_valid)) begin
			out_valid_q <= 1'b1;
		end else if (!cmd_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (ctrl.put_normal && nrm_valid) begin
			out_cmd_q   <= nrm_cmd;
			out_glyph_q <= nrm_glyph;
			out_fore_q  <= nrm_fore;
			out_back_q  <= nrm_back;
			out_attr_q  <= nrm_attr;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_cnt_q   <= '0;
		end else if (ctrl.exec && dec_valid) begin
			out_cmd_q   <= dec_cmd;
			out_glyph_q <= '0;
			out_fore_q  <= '0;
			out_back_q  <= '0;
			out_attr_q  <= '0;
			out_row_q   <= dec_row;
			out_col_q   <= dec_col;
			out_cnt_q   <= dec_cnt;
		end
	end

	assign cmd_valid   = out_valid_q;
	assign command     = out_cmd_q;
	assign glyph       = out_glyph_q;
	assign fore_colour = out_fore_q;
	assign back_colour = out_back_q;
	assign attributes  = out_attr_q;
	assign target_row  = out_row_q;
	assign target_col  = out_col_q;
	assign move_count  = out_cnt_q;

endmodule

`default_nettype wire

// ===== hdl/ansi_escape_sequence_parser.sv =====
// A normal-mode byte gives its item in the result register in the cycle after it is taken.
// A CSI final byte is first committed, then decoded into the result register once that register is free.
// SGR walks the stored parameters through the store's single read port, a read and then an apply step for each.
// Throughput: one byte per cycle outside final-byte execution and SGR walks; input stalls while a result waits.
// Reset clears the parse mode, counters and result flag; colours return to their defaults.
// ----------------------------------------------------------------------------
// ansi_escape_sequence_parser: terminal byte stream to display commands
// Decodes printable bytes, CR, LF, BS and CSI sequences (cursor moves,
// erase, SGR colour and attributes) into one display command per item.
// ----------------------------------------------------------------------------
`default_nettype none

module ansi_escape_sequence_parser #(
	parameter int PARAM_SLOTS = asp_pkg::PARAM_SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          byte_valid,
	output logic                               byte_stall,
	input  wire logic [asp_pkg::BYTE_W-1:0]    byte_in,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [asp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [asp_pkg::COLOUR_W-1:0]  cfg_data,
	output logic                               cmd_valid,
	input  wire logic                          cmd_stall,
	output logic [asp_pkg::CMD_W-1:0]          command,
	output logic [asp_pkg::GLYPH_W-1:0]        glyph,
	output logic [asp_pkg::COLOUR_W-1:0]       fore_colour,
	output logic [asp_pkg::COLOUR_W-1:0]       back_colour,
	output logic [asp_pkg::ATTR_W-1:0]         attributes,
	output logic [asp_pkg::PARAM_W-1:0]        target_row,
	output logic [asp_pkg::PARAM_W-1:0]        target_col,
	output logic [asp_pkg::PARAM_W-1:0]        move_count
);

	asp_pkg::asp_status_t status;
	asp_pkg::asp_ctrl_t   ctrl;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	asp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.status     (status),
		.ctrl       (ctrl)
	);

	asp_datapath #(
		.PARAM_SLOTS (PARAM_SLOTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.status      (status),
		.byte_in     (byte_in),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.command     (command),
		.glyph       (glyph),
		.fore_colour (fore_colour),
		.back_colour (back_colour),
		.attributes  (attributes),
		.target_row  (target_row),
		.target_col  (target_col),
		.move_count  (move_count)
	);

	// The controller issues at most one datapath operation per cycle.
	a_ctrl_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ctrl))
		else $error("more than one datapath operation in a cycle");

	// A result is only loaded when the result register can take it.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.put_normal || ctrl.exec) |-> status.out_free)
		else $error("result register loaded while occupied");

	// Each SGR apply step follows the read of its parameter.
	a_sgr_order: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.sgr_apply |-> $past(ctrl.sgr_read))
		else $error("SGR parameter applied without a preceding read");

	// No byte is taken while a final byte is being executed.
	a_hold_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.exec || ctrl.sgr_read || ctrl.sgr_apply) |-> byte_stall)
		else $error("input taken during command execution");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the terminal escape sequence parser
// Feeds printable text, control bytes, noise and CSI sequences (cursor moves,
// erase, SGR) through the byte channel and checks each display command
// against a behavioral parser kept in a small scoreboard class.
// ----------------------------------------------------------------------------

module testbench;
	import asp_pkg::*;

	localparam int SLOTS = PARAM_SLOTS_DEF;

	// A register index with no register behind it; writes to it are dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'hF;

	// Kinds of CSI parameter values the generator draws from.
	localparam int PK_CURSOR = 0;
	localparam int PK_ERASE  = 1;
	localparam int PK_SGR    = 2;

	// Cycles to let an SGR walk finish when no command is pending.
	localparam int SETTLE_CYCLES  = 40;
	// Receiver hold-off long enough to back the parser up to its input.
	localparam int HOLD_CYCLES    = 300;
	// Longest legal stretch without any handshake is the hold-off above.
	localparam int WATCHDOG_LIMIT = 2000;
	// Counted bytes per random phase.
	localparam int PHASE_BYTES    = 210;

	typedef enum logic [1:0] {PM_NORMAL, PM_ESCAPE, PM_CSI} parse_mode_t;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [GLYPH_W-1:0]  glyph;
		logic [COLOUR_W-1:0] fore;
		logic [COLOUR_W-1:0] back;
		logic [ATTR_W-1:0]   attr;
		logic [PARAM_W-1:0]  row;
		logic [PARAM_W-1:0]  col;
		logic [PARAM_W-1:0]  count;
	} display_cmd_t;

	// Scoreboard: tracks the parser state and the commands still owed.
	class display_scoreboard;
		logic [COLOUR_W-1:0] dflt_fore;
		logic [COLOUR_W-1:0] dflt_back;
		logic [COLOUR_W-1:0] cur_fore;
		logic [COLOUR_W-1:0] cur_back;
		logic [ATTR_W-1:0]   attr_flags;
		parse_mode_t         mode;
		logic [PARAM_W-1:0]  params [SLOTS];
		int unsigned         nparams;
		bit                  digit_seen;
		display_cmd_t        expected_cmds[$];
		int unsigned         mismatches;

		function new();
			dflt_fore = DEFAULT_FG_RST;
			dflt_back = DEFAULT_BG_RST;
			cur_fore = dflt_fore;
			cur_back = dflt_back;
			attr_flags = '0;
			mode = PM_NORMAL;
			foreach (params[i]) params[i] = '0;
			nparams = 0;
			digit_seen = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOUR_W-1:0] data);
			if (idx == CFG_DEFAULT_FG) dflt_fore = data;
			else if (idx == CFG_DEFAULT_BG) dflt_back = data;
		endfunction

		function logic [COLOUR_W-1:0] colour_of(logic [2:0] idx);
			case (idx)
				3'd0: return 32'hFF00_0000;
				3'd1: return 32'hFFFF_5555;
				3'd2: return 32'hFF55_FF55;
				3'd3: return 32'hFFFF_FF55;
				3'd4: return 32'hFF55_55FF;
				3'd5: return 32'hFFFF_55FF;
				3'd6: return 32'hFF55_FFFF;
				default: return 32'hFFCC_CCCC;
			endcase
		endfunction

		function void restore_defaults();
			cur_fore = dflt_fore;
			cur_back = dflt_back;
			attr_flags = '0;
		endfunction

		// SGR walks every stored parameter in order; later ones win.
		function void apply_sgr();
			logic [PARAM_W-1:0] v;
			logic [PARAM_W-1:0] off;
			if (nparams == 0) begin
				restore_defaults();
				return;
			end
			for (int i = 0; i < nparams && i < SLOTS; i++) begin
				v = params[i];
				if (v == SGR_RESET) restore_defaults();
				else if (v == SGR_BOLD) attr_flags |= ATTR_BOLD;
				else if (v == SGR_UNDERLINE) attr_flags |= ATTR_UNDERLINE;
				else if (v == SGR_REVERSE) attr_flags |= ATTR_REVERSE;
				else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
					off = v - SGR_FG_LO;
					cur_fore = colour_of(off[2:0]);
				end else if (v == SGR_FG_DEF) cur_fore = dflt_fore;
				else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
					off = v - SGR_BG_LO;
					cur_back = colour_of(off[2:0]);
				end else if (v == SGR_BG_DEF) cur_back = dflt_back;
			end
		endfunction

		// Decode a CSI final byte; returns 1 when it yields a command.
		function bit decode_final(logic [BYTE_W-1:0] fin, output display_cmd_t r);
			logic [PARAM_W-1:0] p1;
			logic [PARAM_W-1:0] p2;
			logic [PARAM_W-1:0] emode;
			logic [PARAM_W-1:0] cnt;
			bit hit;
			p1 = (nparams > 0) ? params[0] : 16'd1;
			p2 = (nparams > 1) ? params[1] : 16'd1;
			emode = (nparams > 0) ? params[0] : 16'd0;
			cnt = (p1 != 0) ? p1 : 16'd1;
			r = '0;
			hit = 1'b1;
			case (fin)
				CH_CUP, CH_HVP: begin
					r.command = CMD_SET_CURSOR;
					r.row = (p1 != 0) ? p1 - 16'd1 : 16'd0;
					r.col = (p2 != 0) ? p2 - 16'd1 : 16'd0;
				end
				CH_CUU: begin
					r.command = CMD_UP;
					r.count = cnt;
				end
				CH_CUD: begin
					r.command = CMD_DOWN;
					r.count = cnt;
				end
				CH_CUF: begin
					r.command = CMD_FORWARD;
					r.count = cnt;
				end
				CH_CUB: begin
					r.command = CMD_BACK;
					r.count = cnt;
				end
				CH_ED: begin
					if (emode == ERASE_ALL) r.command = CMD_CLR_SCREEN;
					else hit = 1'b0;
				end
				CH_EL: begin
					if (emode == ERASE_FROM) r.command = CMD_CLR_EOL;
					else if (emode == ERASE_TO) r.command = CMD_CLR_BOL;
					else if (emode == ERASE_ALL) r.command = CMD_CLR_LINE;
					else hit = 1'b0;
				end
				CH_SGR: begin
					apply_sgr();
					hit = 1'b0;
				end
				default: hit = 1'b0;
			endcase
			return hit;
		endfunction

		// Advance the parser by one accepted byte and queue what it yields.
		function void take_byte(logic [BYTE_W-1:0] b);
			display_cmd_t r;
			bit hit;
			logic [31:0] acc;
			r = '0;
			hit = 1'b0;
			case (mode)
				PM_NORMAL: begin
					if (b == CH_ESC) mode = PM_ESCAPE;
					else if (b == CH_CR) begin
						r.command = CMD_CR;
						hit = 1'b1;
					end else if (b == CH_LF) begin
						r.command = CMD_NEW_LINE;
						r.back = cur_back;
						hit = 1'b1;
					end else if (b == CH_BS) begin
						r.command = CMD_BACKSPACE;
						hit = 1'b1;
					end else if (b >= CH_PRT_LO && b <= CH_PRT_HI) begin
						r.command = CMD_PUT_CHAR;
						r.glyph = b[GLYPH_W-1:0];
						r.fore = cur_fore;
						r.back = cur_back;
						r.attr = attr_flags;
						hit = 1'b1;
					end
				end
				PM_ESCAPE: begin
					if (b == CH_LBR) begin
						mode = PM_CSI;
						nparams = 0;
						params[0] = '0;
						digit_seen = 1'b0;
					end else mode = PM_NORMAL;
				end
				default: begin
					if (b >= CH_ZERO && b <= CH_NINE) begin
						// Digits accumulate in decimal and saturate at the top.
						if (nparams < SLOTS) begin
							acc = params[nparams] * 10 + (b - CH_ZERO);
							params[nparams] = (acc > 32'd65535) ? 16'hFFFF : acc[15:0];
						end
						digit_seen = 1'b1;
					end else if (b == CH_SEMI) begin
						// A full store swallows further separators.
						if (nparams < SLOTS - 1) begin
							nparams++;
							params[nparams] = '0;
							digit_seen = 1'b0;
						end
					end else if (b >= CH_FIN_LO && b <= CH_FIN_HI) begin
						if (digit_seen && nparams < SLOTS) nparams++;
						mode = PM_NORMAL;
						hit = decode_final(b, r);
					end
				end
			endcase
			if (hit) expected_cmds.push_back(r);
		endfunction

		task report(string field, logic [31:0] got, logic [31:0] want);
			mismatches++;
			// Keep the log readable when something is badly broken.
			if (mismatches <= 100)
				$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
					$time, field, got, want);
		endtask

		task check_command(display_cmd_t got);
			display_cmd_t want;
			if (expected_cmds.size() == 0) begin
				report("command with none expected", got.command, '0);
				return;
			end
			want = expected_cmds.pop_front();
			if (got.command !== want.command) report("command", got.command, want.command);
			if (got.glyph !== want.glyph) report("glyph", got.glyph, want.glyph);
			if (got.fore !== want.fore) report("fore_colour", got.fore, want.fore);
			if (got.back !== want.back) report("back_colour", got.back, want.back);
			if (got.attr !== want.attr) report("attributes", got.attr, want.attr);
			if (got.row !== want.row) report("target_row", got.row, want.row);
			if (got.col !== want.col) report("target_col", got.col, want.col);
			if (got.count !== want.count) report("move_count", got.count, want.count);
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  byte_valid = 1'b0;
	logic                  byte_stall;
	logic [BYTE_W-1:0]     byte_in = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [COLOUR_W-1:0]   cfg_data = '0;
	logic                  cmd_valid;
	logic                  cmd_stall = 1'b0;
	logic [CMD_W-1:0]      command;
	logic [GLYPH_W-1:0]    glyph;
	logic [COLOUR_W-1:0]   fore_colour;
	logic [COLOUR_W-1:0]   back_colour;
	logic [ATTR_W-1:0]     attributes;
	logic [PARAM_W-1:0]    target_row;
	logic [PARAM_W-1:0]    target_col;
	logic [PARAM_W-1:0]    move_count;

	display_scoreboard sb;
	logic [BYTE_W-1:0] stream[$];
	bit no_idle = 1'b0;
	bit hold_phase = 1'b0;
	bit hold_done = 1'b0;
	int unsigned stuck_cycles = 0;

	ansi_escape_sequence_parser #(.PARAM_SLOTS(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_in(byte_in),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.glyph(glyph),
		.fore_colour(fore_colour),
		.back_colour(back_colour),
		.attributes(attributes),
		.target_row(target_row),
		.target_col(target_col),
		.move_count(move_count)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Monitor: note register writes, accepted bytes and delivered commands.
	always @(posedge clk) begin
		display_cmd_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
			if (byte_valid && !byte_stall) sb.take_byte(byte_in);
			if (cmd_valid && !cmd_stall) begin
				got.command = command;
				got.glyph = glyph;
				got.fore = fore_colour;
				got.back = back_colour;
				got.attr = attributes;
				got.row = target_row;
				got.col = target_col;
				got.count = move_count;
				sb.check_command(got);
			end
		end
	end

	// Watchdog: end the run if no handshake happens for too long.
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (cmd_valid && !cmd_stall) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles == WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off when asked for.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_phase && !hold_done) begin
				cmd_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			cmd_stall <= !no_idle && ($urandom_range(99) < 11);
		end
	end

	// Offer one byte, idling first now and then, and wait until it is taken.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (!no_idle && $urandom_range(99) < 11) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_in <= b;
		do @(posedge clk); while (byte_stall);
	endtask

	task automatic pump();
		while (stream.size() != 0) send_byte(stream.pop_front());
	endtask

	// Wait until every owed command has come out and any SGR walk is over.
	task automatic settle();
		byte_valid <= 1'b0;
		while (sb.expected_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Program both default colors and poke the unused index as well.
	task automatic program_colours(input logic [COLOUR_W-1:0] fg, input logic [COLOUR_W-1:0] bg);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [COLOUR_W-1:0] val [3];
		idx[0] = CFG_DEFAULT_FG;
		val[0] = fg;
		idx[1] = CFG_DEFAULT_BG;
		val[1] = bg;
		idx[2] = CFG_SPARE;
		val[2] = $urandom();
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Append a decimal number, sometimes with a leading zero; returns bytes added.
	function automatic int push_number(int unsigned v);
		logic [BYTE_W-1:0] digits[$];
		int n;
		n = 0;
		if ($urandom_range(9) == 0) begin
			stream.push_back(CH_ZERO);
			n++;
		end
		do begin
			digits.push_front(CH_ZERO + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		n += digits.size();
		while (digits.size() != 0) stream.push_back(digits.pop_front());
		return n;
	endfunction

	// A byte that CSI mode drops: not a digit, separator or final byte.
	function automatic logic [BYTE_W-1:0] csi_junk();
		logic [BYTE_W-1:0] b;
		do b = 8'($urandom_range(0, 255));
		while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI ||
			(b >= CH_FIN_LO && b <= CH_FIN_HI));
		return b;
	endfunction

	// Parameter value for a given kind; a negative value leaves it out.
	function automatic int param_value(int kind);
		int r;
		r = $urandom_range(99);
		if (r < 10) return -1;
		if (kind == PK_ERASE) return (r < 80) ? $urandom_range(0, 2) : $urandom_range(3, 300);
		if (kind == PK_SGR) begin
			r = $urandom_range(23);
			if (r < 8) return SGR_FG_LO + r;
			if (r < 16) return SGR_BG_LO + r - 8;
			case (r)
				16: return SGR_RESET;
				17: return SGR_BOLD;
				18: return SGR_UNDERLINE;
				19: return SGR_REVERSE;
				20: return SGR_FG_DEF;
				21: return SGR_BG_DEF;
				default: return $urandom_range(0, 120);
			endcase
		end
		if (r < 20) return 0;
		if (r < 70) return $urandom_range(1, 99);
		if (r < 85) return $urandom_range(100, 999);
		if (r < 92) return $urandom_range(65534, 65536);
		return $urandom_range(65537, 99999999);
	endfunction

	function automatic int param_total();
		int r;
		r = $urandom_range(99);
		if (r < 20) return 0;
		if (r < 65) return 1;
		if (r < 88) return 2;
		return $urandom_range(3, SLOTS + 4);
	endfunction

	// Append ESC [ params final, with a stray ignored byte now and then.
	function automatic int push_csi(logic [BYTE_W-1:0] fin, int n, int kind);
		int cnt;
		int v;
		stream.push_back(CH_ESC);
		stream.push_back(CH_LBR);
		cnt = 2;
		for (int i = 0; i < n; i++) begin
			if (i > 0) begin
				stream.push_back(CH_SEMI);
				cnt++;
			end
			v = param_value(kind);
			if (v >= 0) cnt += push_number(v);
			if ($urandom_range(99) < 4) stream.push_back(csi_junk());
		end
		stream.push_back(fin);
		return cnt + 1;
	endfunction

	// Queue one random chunk of traffic; returns the bytes that count as work.
	function automatic int gen_chunk();
		int pick;
		int n;
		logic [BYTE_W-1:0] fin;
		pick = $urandom_range(99);
		if (pick < 30) begin
			n = $urandom_range(1, 8);
			repeat (n) begin
				case ($urandom_range(9))
					0: stream.push_back(CH_CR);
					1: stream.push_back(CH_LF);
					2: stream.push_back(CH_BS);
					default: stream.push_back(8'($urandom_range(CH_PRT_LO, CH_PRT_HI)));
				endcase
			end
			return n;
		end else if (pick < 70) begin
			case ($urandom_range(7))
				0: fin = CH_CUP;
				1: fin = CH_HVP;
				2: fin = CH_CUU;
				3: fin = CH_CUD;
				4: fin = CH_CUF;
				5: fin = CH_CUB;
				6: fin = CH_ED;
				default: fin = CH_EL;
			endcase
			return push_csi(fin, param_total(),
				(fin == CH_ED || fin == CH_EL) ? PK_ERASE : PK_CURSOR);
		end else if (pick < 86) begin
			return push_csi(CH_SGR, param_total(), PK_SGR);
		end else if (pick < 91) begin
			fin = 8'($urandom_range(CH_FIN_LO, CH_FIN_HI));
			return push_csi(fin, param_total(), PK_CURSOR);
		end else if (pick < 96) begin
			// Line noise in normal mode.
			stream.push_back(8'($urandom_range(0, 255)));
			return 0;
		end
		// Escape followed by something other than a bracket.
		stream.push_back(CH_ESC);
		do fin = 8'($urandom_range(0, 255)); while (fin == CH_LBR);
		stream.push_back(fin);
		return 1;
	endfunction

	// Main sequence: reset, directed bytes, then random phases per color setting.
	initial begin
		int done_bytes;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes, ignored bytes, dropped escape, saturation, clear screen.
		stream = '{CH_PRT_LO, CH_PRT_HI, CH_CR, CH_LF, CH_BS, 8'h00, 8'h7F, 8'hFF,
			CH_ESC, 8'h5A,
			CH_ESC, CH_LBR, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_SEMI,
			CH_ZERO, CH_CUP,
			CH_ESC, CH_LBR, 8'h32, CH_ED};
		pump();

		for (int ph = 0; ph < 5; ph++) begin
			settle();
			case (ph)
				0: program_colours(32'h0000_0000, 32'hFFFF_FFFF);
				1: program_colours(32'hFFFF_FFFF, 32'h0000_0000);
				default: program_colours($urandom(), $urandom());
			endcase
			no_idle = (ph == 2);
			if (ph == 1) begin
				// Plenty of printable bytes while the receiver holds off.
				hold_phase = 1'b1;
				repeat (40) stream.push_back(8'($urandom_range(CH_PRT_LO, CH_PRT_HI)));
				pump();
			end
			done_bytes = 0;
			while (done_bytes < PHASE_BYTES) begin
				done_bytes += gen_chunk();
				pump();
			end
		end
		no_idle = 1'b0;
		settle();

		if (sb.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/asp_pkg.sv
hdl/asp_ctrl.sv
hdl/asp_datapath.sv
hdl/ansi_escape_sequence_parser.sv
tb/testbench.sv
